// ----- hdl/lfu_page_replacement_macros.svh -----
// Assertion macros shared by the LFU page replacement block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, inactive while reset is held.
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is held.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lfu_pkg.sv -----
// Types and fixed widths for the LFU page replacement block.
// No dependencies.
package lfu_pkg;

    localparam int unsigned PAGE_W    = 16;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned TOTAL_W   = 32;
    localparam int unsigned CFG_W     = 5;
    localparam int unsigned IDX_OUT_W = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

// ----- hdl/lfu_if.sv -----
// Valid/ready channel interfaces for page references and replacement results.
// Depends on lfu_pkg.
interface lfu_in_if import lfu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lfu_out_if import lfu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame_index;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output hit_total, output fault_total, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input hit_total, input fault_total, output ready);
endinterface

// ----- hdl/lfu_page_replacement.sv -----
// Top level of the LFU page replacement block: configuration register, frame
// memory and scan sequencer. Depends on lfu_pkg, lfu_if, lfu_frame_mem, lfu_ctrl.
//
// Each page reference is looked up by reading the managed frames one per cycle
// from the single read port of the frame memory, then the chosen frame is written
// back in the write state, which waits while the output register still holds an
// untaken result. The result is held in that output register so the next item can
// be taken while it waits. Frame contents are not cleared by reset; only the valid
// marks are, so no clearing pass is needed.
module lfu_page_replacement import lfu_pkg::*; #(
    parameter int unsigned MAX_FRAMES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lfu_in_if.sink           i_req,
    lfu_out_if.source        o_rsp
);

    localparam int unsigned FW = $clog2(MAX_FRAMES);
    localparam int unsigned NW = $clog2(MAX_FRAMES + 1);

    logic [CFG_W-1:0] r_frames_in_use;
    logic             w_mem_we;
    logic [FW-1:0]    w_mem_waddr;
    t_entry           w_mem_wdata;
    logic [FW-1:0]    w_mem_raddr;
    t_entry           w_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    lfu_frame_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (FW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    lfu_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .FW         (FW),
        .NW         (NW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frames_in_use (r_frames_in_use),
        .i_req           (i_req),
        .o_rsp           (o_rsp),
        .o_mem_we        (w_mem_we),
        .o_mem_waddr     (w_mem_waddr),
        .o_mem_wdata     (w_mem_wdata),
        .o_mem_raddr     (w_mem_raddr),
        .i_mem_rdata     (w_mem_rdata)
    );

endmodule

// ----- hdl/lfu_frame_mem.sv -----
// Frame table memory: page number and use count per frame, one write and one
// registered read port. Depends on lfu_pkg.
module lfu_frame_mem import lfu_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lfu_ctrl.sv -----
// Sequencer that scans the frame table, picks hit, empty or victim frame and
// writes back. Depends on lfu_pkg, lfu_if and lfu_frame_mem read timing.
`include "lfu_page_replacement_macros.svh"

module lfu_ctrl import lfu_pkg::*; #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned FW         = 4,
    parameter int unsigned NW         = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_frames_in_use,
    lfu_in_if.sink           i_req,
    lfu_out_if.source        o_rsp,
    output logic             o_mem_we,
    output logic [FW-1:0]    o_mem_waddr,
    output t_entry           o_mem_wdata,
    output logic [FW-1:0]    o_mem_raddr,
    input  t_entry           i_mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    t_state                  r_state;
    logic [MAX_FRAMES-1:0]   r_valid;
    logic [NW-1:0]           r_n;
    logic [FW-1:0]           r_idx;
    logic [PAGE_W-1:0]       r_page;
    logic                    r_found;
    logic [FW-1:0]           r_hit_at;
    logic [COUNT_W-1:0]      r_hit_cnt;
    logic                    r_have_empty;
    logic [FW-1:0]           r_empty_at;
    logic [COUNT_W:0]        r_min;
    logic [FW-1:0]           r_victim;
    logic [PAGE_W-1:0]       r_victim_page;
    logic [TOTAL_W-1:0]      r_hit_total;
    logic [TOTAL_W-1:0]      r_fault_total;
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic [IDX_OUT_W-1:0]    r_out_idx;
    logic                    r_out_ev_valid;
    logic [PAGE_W-1:0]       r_out_ev_page;

    logic [NW-1:0]           n_n;
    logic                    w_out_free;
    logic                    w_last;
    logic                    w_cur_valid;
    logic                    w_evict;
    logic [FW-1:0]           w_slot;
    logic [COUNT_W-1:0]      w_new_count;

    always_comb begin
        if (i_frames_in_use == '0) begin
            n_n = NW'(1);
        end else if (32'(i_frames_in_use) > MAX_FRAMES) begin
            n_n = NW'(MAX_FRAMES);
        end else begin
            n_n = NW'(i_frames_in_use);
        end
    end

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_last      = (NW'(r_idx) == (r_n - NW'(1)));
    assign w_cur_valid = r_valid[r_idx];
    assign w_evict     = !r_found && !r_have_empty;
    assign w_slot      = r_found ? r_hit_at : (r_have_empty ? r_empty_at : r_victim);
    assign w_new_count = r_found ? ((r_hit_cnt == COUNT_MAX) ? r_hit_cnt
                                                             : r_hit_cnt + COUNT_ONE)
                                 : COUNT_ONE;

    assign i_req.ready = (r_state == S_IDLE);

    assign o_mem_raddr       = (r_state == S_SCAN) ? r_idx + FW'(1) : '0;
    assign o_mem_we          = (r_state == S_WRITE) && w_out_free;
    assign o_mem_waddr       = w_slot;
    assign o_mem_wdata.page  = r_page;
    assign o_mem_wdata.count = w_new_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_hit_total   <= '0;
            r_fault_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_page       <= i_req.page_number;
                        r_n          <= n_n;
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_have_empty <= 1'b0;
                        r_min        <= {1'b1, {COUNT_W{1'b0}}};
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_cur_valid) begin
                        if (!r_found && (i_mem_rdata.page == r_page)) begin
                            r_found   <= 1'b1;
                            r_hit_at  <= r_idx;
                            r_hit_cnt <= i_mem_rdata.count;
                        end
                        if ({1'b0, i_mem_rdata.count} < r_min) begin
                            r_min         <= {1'b0, i_mem_rdata.count};
                            r_victim      <= r_idx;
                            r_victim_page <= i_mem_rdata.page;
                        end
                    end else if (!r_have_empty) begin
                        r_have_empty <= 1'b1;
                        r_empty_at   <= r_idx;
                    end
                    if (w_last) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_idx <= r_idx + FW'(1);
                    end
                end
                S_WRITE: begin
                    if (w_out_free) begin
                        r_valid[w_slot] <= 1'b1;
                        if (r_found) begin
                            if (r_hit_total != TOTAL_MAX) begin
                                r_hit_total <= r_hit_total + 32'd1;
                            end
                        end else if (r_fault_total != TOTAL_MAX) begin
                            r_fault_total <= r_fault_total + 32'd1;
                        end
                        r_out_valid    <= 1'b1;
                        r_out_hit      <= r_found;
                        r_out_idx      <= IDX_OUT_W'(w_slot);
                        r_out_ev_valid <= w_evict;
                        r_out_ev_page  <= w_evict ? r_victim_page : '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.frame_index   = r_out_idx;
    assign o_rsp.evicted_valid = r_out_ev_valid;
    assign o_rsp.evicted_page  = r_out_ev_page;
    assign o_rsp.hit_total     = r_hit_total;
    assign o_rsp.fault_total   = r_fault_total;

    `LFU_ASSERT_NOW(a_scan_in_range, r_state == S_SCAN,
                    (r_n != '0) && (NW'(r_idx) < r_n), "scan index outside managed frames")
    `LFU_ASSERT_NOW(a_victim_found, (r_state == S_WRITE) && w_evict,
                    r_min[COUNT_W] == 1'b0, "eviction without a valid victim")
    `LFU_ASSERT_NOW(a_hit_no_evict, o_rsp.valid && o_rsp.hit,
                    !o_rsp.evicted_valid, "hit reported together with eviction")
    `LFU_ASSERT_NEXT(a_slot_valid, o_mem_we, r_valid != '0, "written frame not marked valid")

endmodule
